// ===== hdl/ttbg_pkg.sv =====
`timescale 1ns / 1ps

package ttbg_pkg;

  // configuration register indexes
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_AW-1:0] REG_BURST_LEN  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_AMPLITUDE  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_LOCKOUT_MS = 2'd3;

  localparam logic [22:0] PHASE_STEP_RST = 23'd307582;
  localparam logic [11:0] BURST_LEN_RST  = 12'd3840;
  localparam logic [14:0] AMPLITUDE_RST  = 15'd7000;
  localparam logic [15:0] LOCKOUT_MS_RST = 16'd120;

  // fixed-point layout of the shared multiplier
  localparam int MUL_W       = 30;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int Q_W         = 23;   // amp*e*mag >> 15
  localparam int QUO_W       = 16;   // quotient estimate
  localparam int RECIP_SHIFT = 32;

  typedef logic [3:0] step_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_MUL_AM,
    OP_MUL_E,
    OP_MUL_RECIP,
    OP_MUL_R,
    OP_FINISH,
    OP_TOUCH,
    OP_IDLE
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_IF_TOUCH,
    C_IF_IDLE,
    C_WAIT_OUT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  localparam step_t ST_FETCH    = 4'd0;
  localparam step_t ST_DISPATCH = 4'd1;
  localparam step_t ST_START    = 4'd2;
  localparam step_t ST_MUL_AM   = 4'd3;
  localparam step_t ST_MUL_E    = 4'd4;
  localparam step_t ST_MUL_RCP  = 4'd5;
  localparam step_t ST_MUL_R    = 4'd6;
  localparam step_t ST_FINISH   = 4'd7;
  localparam step_t ST_TOUCH    = 4'd8;
  localparam step_t ST_IDLE     = 4'd9;

  // microcode store
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    case (s)
      ST_FETCH:    c = '{op: OP_NONE,      cond: C_WAIT_IN,  target: ST_FETCH};
      ST_DISPATCH: c = '{op: OP_NONE,      cond: C_IF_TOUCH, target: ST_TOUCH};
      ST_START:    c = '{op: OP_START,     cond: C_IF_IDLE,  target: ST_IDLE};
      ST_MUL_AM:   c = '{op: OP_MUL_AM,    cond: C_NEXT,     target: ST_FETCH};
      ST_MUL_E:    c = '{op: OP_MUL_E,     cond: C_NEXT,     target: ST_FETCH};
      ST_MUL_RCP:  c = '{op: OP_MUL_RECIP, cond: C_NEXT,     target: ST_FETCH};
      ST_MUL_R:    c = '{op: OP_MUL_R,     cond: C_NEXT,     target: ST_FETCH};
      ST_FINISH:   c = '{op: OP_FINISH,    cond: C_WAIT_OUT, target: ST_FETCH};
      ST_TOUCH:    c = '{op: OP_TOUCH,     cond: C_WAIT_OUT, target: ST_FETCH};
      ST_IDLE:     c = '{op: OP_IDLE,      cond: C_WAIT_OUT, target: ST_FETCH};
      default:     c = '{op: OP_NONE,      cond: C_JUMP,     target: ST_FETCH};
    endcase
    return c;
  endfunction

  // Q1.15 sine entry j of a 2^bits table; quarter wave from a Q30 odd polynomial
  function automatic logic signed [15:0] sine_entry(input int unsigned j,
                                                    input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] v;
    int unsigned quarter;
    int unsigned q;
    int unsigned r;
    int unsigned k;
    quarter = 1 << (bits - 2);
    q = j >> (bits - 2);
    r = j & (quarter - 1);
    k = ((q & 1) != 0) ? quarter - r : r;
    x  = 64'(k) << (30 - (bits - 2));
    x2 = (x * x) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995    - ((x2 * p) >> 30);
    p  = 64'd85569306   - ((x2 * p) >> 30);
    p  = 64'd693598668  - ((x2 * p) >> 30);
    p  = 64'd1686629713 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return ((q & 2) != 0) ? -$signed(v[15:0]) : $signed(v[15:0]);
  endfunction

endpackage

// ===== hdl/touch_tone_burst_generator.sv =====
// A touch item walks fetch, dispatch and touch; a sample tick walks fetch, dispatch,
// start, the four multiply steps and finish, or start and idle when no burst is queued.
// One item is taken at a time, through the one shared 30x30 multiplier (four products
// per sample); the next item can be taken once its result is loaded, while that waits.
// Reset (rst, synchronous, active high): registers to their defaults, queue empty,
// no burst playing, phase and lockout history cleared.
`timescale 1ns / 1ps

module touch_tone_burst_generator #(
  parameter int SINE_TABLE_BITS = 8,
  parameter int RAMP_LEN        = 64,
  parameter int QUEUE_DEPTH     = 8,
  parameter int MAX_BURST       = 3840
) (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // [31:0] now_ms
  input  logic                          s_tuser,   // [0] cmd: 0 touch, 1 sample tick
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [15:0]                   m_tdata,   // [15:0] sample (signed)
  output logic                          m_tlast,   // burst_last
  output logic [1:0]                    m_tuser,   // [0] sample_valid, [1] touch_accepted
  // configuration writes
  input  logic                          cfg_we,
  input  logic [ttbg_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [22:0]                   cfg_wdata
);

  localparam int TAB_SIZE = 1 << SINE_TABLE_BITS;
  localparam int PW       = $clog2(QUEUE_DEPTH + 1);
  localparam int EW       = $clog2(RAMP_LEN + 1);
  // floor(2^32 / RAMP_LEN): quotient estimate is low by at most one
  localparam logic [63:0] RECIP_FULL = (64'd1 << ttbg_pkg::RECIP_SHIFT) / RAMP_LEN;
  localparam logic [ttbg_pkg::MUL_W-1:0] RECIP = RECIP_FULL[ttbg_pkg::MUL_W-1:0];

  // sine table, built at elaboration
  logic signed [15:0] sine_rom [TAB_SIZE];
  for (genvar j = 0; j < TAB_SIZE; j++) begin : g_sine
    assign sine_rom[j] = ttbg_pkg::sine_entry(j, SINE_TABLE_BITS);
  end

  // configuration registers
  logic [22:0] phase_step;
  logic [11:0] burst_len;
  logic [14:0] amplitude;
  logic [15:0] lockout_ms;

  // block state
  logic [31:0]   last_touch_time;
  logic [PW-1:0] pending_bursts;
  logic          active;
  logic [11:0]   sample_index;
  logic [23:0]   phase_acc;

  // sequencer
  ttbg_pkg::step_t step;
  ttbg_pkg::step_t step_next;
  ttbg_pkg::ctrl_t ctrl;

  // datapath
  logic                            cmd;
  logic [31:0]                     now_ms;
  logic                            neg;
  logic [ttbg_pkg::PROD_W-1:0]     prod;
  logic [ttbg_pkg::Q_W-1:0]        q_full;
  logic [ttbg_pkg::QUO_W-1:0]      quo;
  logic [ttbg_pkg::MUL_W-1:0]      mul_a;
  logic [ttbg_pkg::MUL_W-1:0]      mul_b;

  logic        in_accept;
  logic        out_free;
  logic        res_load;
  logic        no_burst;
  logic        locked;
  logic        q_has_room;
  logic [11:0] n_clip;
  logic [11:0] n_eff;
  logic [12:0] idx_plus_ramp;
  logic [EW-1:0] env;
  logic        is_last;
  logic signed [15:0] tab_val;
  logic [14:0] tab_mag;
  logic [23:0] rem;
  logic [16:0] mag_q;
  logic [16:0] mag_sat;
  logic [15:0] sample_val;

  assign ctrl      = ttbg_pkg::ucode(step);
  assign s_tready  = (ctrl.cond == ttbg_pkg::C_WAIT_IN);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign no_burst  = !active && (pending_bursts == '0);

  // the result register loads only on a result step once the old item has left or is being taken
  assign res_load  = out_free &&
                     (ctrl.op inside {ttbg_pkg::OP_FINISH, ttbg_pkg::OP_TOUCH,
                                      ttbg_pkg::OP_IDLE});

  // touch lockout and queue room
  assign locked = (last_touch_time != 32'd0) && (now_ms > last_touch_time) &&
                  ((now_ms - last_touch_time) < {16'd0, lockout_ms});
  assign q_has_room = (pending_bursts < PW'(QUEUE_DEPTH));

  // effective burst length and envelope
  always_comb begin
    n_clip        = (burst_len > 12'(MAX_BURST)) ? 12'(MAX_BURST) : burst_len;
    n_eff         = (n_clip == 12'd0) ? 12'd1 : n_clip;
    idx_plus_ramp = {1'b0, sample_index} + 13'(RAMP_LEN);
    if (sample_index < 12'(RAMP_LEN)) begin
      env = EW'(sample_index);
    end else if (idx_plus_ramp > {1'b0, n_eff}) begin
      env = (n_eff > sample_index) ? EW'(n_eff - sample_index) : '0;
    end else begin
      env = EW'(RAMP_LEN);
    end
    is_last = ({1'b0, sample_index} + 13'd1) >= {1'b0, n_eff};
  end

  assign tab_val = sine_rom[phase_acc[23 -: SINE_TABLE_BITS]];
  assign tab_mag = tab_val[15] ? 15'(-tab_val) : tab_val[14:0];

  // shared multiplier operand select
  always_comb begin
    case (ctrl.op)
      ttbg_pkg::OP_MUL_AM: begin
        mul_a = ttbg_pkg::MUL_W'(amplitude);
        mul_b = ttbg_pkg::MUL_W'(tab_mag);
      end
      ttbg_pkg::OP_MUL_E: begin
        mul_a = prod[ttbg_pkg::MUL_W-1:0];
        mul_b = ttbg_pkg::MUL_W'(env);
      end
      ttbg_pkg::OP_MUL_RECIP: begin
        mul_a = ttbg_pkg::MUL_W'(prod[15 +: ttbg_pkg::Q_W]);
        mul_b = RECIP;
      end
      ttbg_pkg::OP_MUL_R: begin
        mul_a = ttbg_pkg::MUL_W'(prod[ttbg_pkg::RECIP_SHIFT +: ttbg_pkg::QUO_W]);
        mul_b = ttbg_pkg::MUL_W'(RAMP_LEN);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // quotient correction, saturation and sign
  always_comb begin
    rem     = {1'b0, q_full} - prod[23:0];
    mag_q   = {1'b0, quo} + ((rem >= 24'(RAMP_LEN)) ? 17'd1 : 17'd0);
    if (neg) begin
      mag_sat    = (mag_q > 17'd32768) ? 17'd32768 : mag_q;
      sample_val = 16'(-mag_sat);
    end else begin
      mag_sat    = (mag_q > 17'd32767) ? 17'd32767 : mag_q;
      sample_val = mag_sat[15:0];
    end
  end

  // step counter: next step
  always_comb begin
    case (ctrl.cond)
      ttbg_pkg::C_NEXT:     step_next = step + 4'd1;
      ttbg_pkg::C_JUMP:     step_next = ctrl.target;
      ttbg_pkg::C_WAIT_IN:  step_next = in_accept ? step + 4'd1 : step;
      ttbg_pkg::C_IF_TOUCH: step_next = !cmd ? ctrl.target : step + 4'd1;
      ttbg_pkg::C_IF_IDLE:  step_next = no_burst ? ctrl.target : step + 4'd1;
      ttbg_pkg::C_WAIT_OUT: step_next = out_free ? ctrl.target : step;
      default:              step_next = ttbg_pkg::ST_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ttbg_pkg::ST_FETCH;
    end else begin
      step <= step_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= ttbg_pkg::PHASE_STEP_RST;
      burst_len  <= ttbg_pkg::BURST_LEN_RST;
      amplitude  <= ttbg_pkg::AMPLITUDE_RST;
      lockout_ms <= ttbg_pkg::LOCKOUT_MS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        ttbg_pkg::REG_PHASE_STEP: phase_step <= cfg_wdata;
        ttbg_pkg::REG_BURST_LEN:  burst_len  <= cfg_wdata[11:0];
        ttbg_pkg::REG_AMPLITUDE:  amplitude  <= cfg_wdata[14:0];
        ttbg_pkg::REG_LOCKOUT_MS: lockout_ms <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd    <= s_tuser;
      now_ms <= s_tdata;
    end
    case (ctrl.op)
      ttbg_pkg::OP_MUL_AM: begin
        prod <= mul_a * mul_b;
        neg  <= tab_val[15];
      end
      ttbg_pkg::OP_MUL_E: begin
        prod <= mul_a * mul_b;
      end
      ttbg_pkg::OP_MUL_RECIP: begin
        prod   <= mul_a * mul_b;
        q_full <= prod[15 +: ttbg_pkg::Q_W];
      end
      ttbg_pkg::OP_MUL_R: begin
        prod <= mul_a * mul_b;
        quo  <= prod[ttbg_pkg::RECIP_SHIFT +: ttbg_pkg::QUO_W];
      end
      default: ;
    endcase
  end

  // result valid: set on a load, dropped once the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // burst state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_touch_time <= 32'd0;
      pending_bursts  <= '0;
      active          <= 1'b0;
      sample_index    <= 12'd0;
      phase_acc       <= 24'd0;
      m_tdata         <= 16'd0;
      m_tlast         <= 1'b0;
      m_tuser         <= 2'b00;
    end else begin
      case (ctrl.op)
        ttbg_pkg::OP_START: begin
          // pick up the next queued burst when none is playing
          if (!active && (pending_bursts != '0)) begin
            pending_bursts <= pending_bursts - PW'(1);
            active         <= 1'b1;
            sample_index   <= 12'd0;
            phase_acc      <= 24'd0;
          end
        end
        ttbg_pkg::OP_FINISH: begin
          if (out_free) begin
            m_tdata   <= sample_val;
            m_tlast   <= is_last;
            m_tuser   <= 2'b01;
            phase_acc <= phase_acc + {1'b0, phase_step};
            if (is_last) begin
              active       <= 1'b0;
              sample_index <= 12'd0;
            end else begin
              sample_index <= sample_index + 12'd1;
            end
          end
        end
        ttbg_pkg::OP_TOUCH: begin
          if (out_free) begin
            m_tdata  <= 16'd0;
            m_tlast  <= 1'b0;
            m_tuser  <= {!locked && q_has_room, 1'b0};
            if (!locked) begin
              last_touch_time <= now_ms;
              if (q_has_room) begin
                pending_bursts <= pending_bursts + PW'(1);
              end
            end
          end
        end
        ttbg_pkg::OP_IDLE: begin
          if (out_free) begin
            m_tdata  <= 16'd0;
            m_tlast  <= 1'b0;
            m_tuser  <= 2'b00;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/tb_touch_tone_burst_generator.sv =====
`timescale 1ns / 1ps

module tb_touch_tone_burst_generator;

  // block geometry, mirrored from the instance parameters below
  localparam int TONE_TAB_BITS    = 8;
  localparam int TONE_TAB_SIZE    = 1 << TONE_TAB_BITS;
  localparam int TONE_QUARTER     = TONE_TAB_SIZE / 4;
  localparam int RAMP             = 64;
  localparam int TONE_QUEUE_DEPTH = 8;
  localparam int LONGEST_BURST    = 3840;

  // tuser on the input side
  localparam logic CMD_TOUCH = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam int RANDOM_ITEMS = 900;
  localparam int DRAIN_CYCLES = 12;

  // one result item, fields in the order they are compared
  typedef struct packed {
    logic signed [15:0] sample;
    logic               sample_valid;
    logic               burst_last;
    logic               touch_accepted;
  } tone_result_t;

  // Tone predictor plus the store of results it has promised.
  class tone_scoreboard;
    logic [22:0]        phase_step;
    logic [11:0]        burst_len;
    logic [14:0]        amplitude;
    logic [15:0]        lockout_ms;
    logic [31:0]        last_touch;
    int unsigned        queued;
    bit                 playing;
    logic [11:0]        sample_idx;
    logic [23:0]        phase;
    logic signed [15:0] sine_rom [TONE_TAB_SIZE];
    tone_result_t       due [$];
    int                 errors;
    bit                 was_ignored;

    function new();
      int unsigned quad;
      int unsigned pos;
      logic [63:0] mag;
      phase_step = ttbg_pkg::PHASE_STEP_RST;
      burst_len  = ttbg_pkg::BURST_LEN_RST;
      amplitude  = ttbg_pkg::AMPLITUDE_RST;
      lockout_ms = ttbg_pkg::LOCKOUT_MS_RST;
      last_touch = '0;
      queued     = 0;
      playing    = 1'b0;
      sample_idx = '0;
      phase      = '0;
      errors     = 0;
      for (int j = 0; j < TONE_TAB_SIZE; j++) begin
        quad = j / TONE_QUARTER;
        pos  = j % TONE_QUARTER;
        // odd quadrants run the quarter wave backwards, the lower half is negated
        mag  = quarter_wave(((quad & 1) != 0) ? TONE_QUARTER - pos : pos);
        sine_rom[j[TONE_TAB_BITS-1:0]] = ((quad & 2) != 0) ? -$signed(mag[15:0])
                                                           : $signed(mag[15:0]);
      end
    endfunction

    // 32767*sin(pi/2 * k/quarter), Q30 odd polynomial evaluated by Horner
    function logic [63:0] quarter_wave(int unsigned k);
      logic [63:0] ang;
      logic [63:0] ang2;
      logic [63:0] acc;
      logic [63:0] coef [4];
      coef[0] = 64'd5026995;
      coef[1] = 64'd85569306;
      coef[2] = 64'd693598668;
      coef[3] = 64'd1686629713;
      ang  = 64'(k) << (30 - (TONE_TAB_BITS - 2));
      ang2 = (ang * ang) >> 30;
      acc  = 64'd172272;
      for (int c = 0; c < 4; c++) begin
        acc = coef[c] - ((ang2 * acc) >> 30);
      end
      acc = (ang * acc) >> 30;
      acc = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      return (acc > 64'd32767) ? 64'd32767 : acc;
    endfunction

    function void write_reg(logic [ttbg_pkg::CFG_AW-1:0] idx, logic [22:0] val);
      case (idx)
        ttbg_pkg::REG_PHASE_STEP: phase_step = val[22:0];
        ttbg_pkg::REG_BURST_LEN:  burst_len  = val[11:0];
        ttbg_pkg::REG_AMPLITUDE:  amplitude  = val[14:0];
        ttbg_pkg::REG_LOCKOUT_MS: lockout_ms = val[15:0];
        default: ;
      endcase
    endfunction

    // advance the tone state by one accepted item and queue its result
    function void note_item(logic cmd, logic [31:0] now);
      tone_result_t r;
      int unsigned  n;
      int unsigned  i;
      int unsigned  env;
      int           mag;
      int           v;
      logic [63:0]  prod;
      logic signed [15:0] t;
      r = '0;
      was_ignored = 1'b0;
      if (cmd == CMD_TOUCH) begin
        // inside the lockout window only when strictly later than the last touch
        if (last_touch != 0 && now > last_touch && (now - last_touch) < 32'(lockout_ms)) begin
          was_ignored = 1'b1;
        end else begin
          last_touch = now;
          if (queued < TONE_QUEUE_DEPTH) begin
            queued++;
            r.touch_accepted = 1'b1;
          end
        end
        due.push_back(r);
        return;
      end
      if (!playing) begin
        if (queued == 0) begin
          due.push_back(r);
          return;
        end
        queued--;
        playing    = 1'b1;
        sample_idx = '0;
        phase      = '0;
      end
      n = (burst_len > LONGEST_BURST) ? LONGEST_BURST : burst_len;
      if (n == 0) n = 1;
      i = sample_idx;
      if (i < RAMP) env = i;
      else if (i + RAMP > n) env = (n > i) ? n - i : 0;
      else env = RAMP;

      t    = sine_rom[phase[23 -: TONE_TAB_BITS]];
      mag  = (t < 0) ? -int'(t) : int'(t);
      prod = (64'(amplitude) * 64'(env) * 64'(mag)) / (64'(RAMP) * 64'd32768);
      if (t < 0) begin
        if (prod > 64'd32768) prod = 64'd32768;
        v = -int'(prod);
      end else begin
        if (prod > 64'd32767) prod = 64'd32767;
        v = int'(prod);
      end
      r.sample       = v[15:0];
      r.sample_valid = 1'b1;
      phase = phase + 24'(phase_step);
      if (i + 1 >= n) begin
        r.burst_last = 1'b1;
        playing      = 1'b0;
        sample_idx   = '0;
      end else begin
        sample_idx = 12'(i + 1);
      end
      due.push_back(r);
    endfunction

    function void check_result(logic [15:0] data, logic last, logic [1:0] user);
      tone_result_t want;
      tone_result_t got;
      got = {data, user[0], last, user[1]};
      if (due.size() == 0) begin
        $display("%0t: result with nothing due: sample %0d valid %0b last %0b accepted %0b",
                 $time, got.sample, got.sample_valid, got.burst_last, got.touch_accepted);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected sample %0d valid %0b last %0b accepted %0b",
                 $time, want.sample, want.sample_valid, want.burst_last, want.touch_accepted);
        $display("%0t:          actual   sample %0d valid %0b last %0b accepted %0b",
                 $time, got.sample, got.sample_valid, got.burst_last, got.touch_accepted);
        errors++;
      end
    endfunction
  endclass

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        s_tvalid  = 1'b0;
  logic                        s_tready;
  logic [31:0]                 s_tdata   = '0;
  logic                        s_tuser   = 1'b0;
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  logic [15:0]                 m_tdata;
  logic                        m_tlast;
  logic [1:0]                  m_tuser;
  logic                        cfg_we    = 1'b0;
  logic [ttbg_pkg::CFG_AW-1:0] cfg_addr  = '0;
  logic [22:0]                 cfg_wdata = '0;

  tone_scoreboard board = new();

  int          fed_items  = 0;   // accepted items that were not locked out
  int          burst_left = 0;   // items left in the current sender burst
  logic [31:0] ms_now     = '0;  // running touch clock

  touch_tone_burst_generator #(
    .SINE_TABLE_BITS(TONE_TAB_BITS),
    .RAMP_LEN       (RAMP),
    .QUEUE_DEPTH    (TONE_QUEUE_DEPTH),
    .MAX_BURST      (LONGEST_BURST)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Offer one item and hold it until taken. Valid stays up across a burst;
  // at the end of a burst it drops for a random gap.
  task automatic send_item(input logic cmd, input logic [31:0] now);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= now;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(cmd, now);
    if (!board.was_ignored) fed_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      // now and then a long run with no gaps at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 100)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Stop sending, let every promised result come out, then let the
  // pipeline go quiet before registers change.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ttbg_pkg::CFG_AW-1:0] idx, input logic [22:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  // back-to-back writes of all four registers; we drops once at the end
  task automatic program_regs(input logic [22:0] step, input logic [22:0] len,
                              input logic [22:0] amp, input logic [22:0] lock);
    cfg_write(ttbg_pkg::REG_PHASE_STEP, step);
    cfg_write(ttbg_pkg::REG_BURST_LEN, len);
    cfg_write(ttbg_pkg::REG_AMPLITUDE, amp);
    cfg_write(ttbg_pkg::REG_LOCKOUT_MS, lock);
    cfg_we <= 1'b0;
  endtask

  // One random setting followed by a run of touches and ticks. Touch times
  // mostly clear the lockout so bursts get queued and played out.
  task automatic random_phase();
    logic [22:0] step;
    logic [22:0] len;
    logic [22:0] amp;
    logic [22:0] lock;
    logic [31:0] now;
    int unsigned r;
    int unsigned n_items;
    int unsigned tick_pct;

    r = $urandom_range(0, 7);
    if (r == 0) step = 23'd1;
    else if (r == 1) step = 23'h7FFFFF;
    else if (r == 2) step = ttbg_pkg::PHASE_STEP_RST;
    else if (r < 5) step = 23'($urandom_range(1, 4000));
    else step = 23'($urandom());

    // short bursts mostly, so attack, plateau and release all get played
    r = $urandom_range(0, 15);
    case (r)
      0:       len = 23'd0;
      1:       len = 23'd1;
      2:       len = 23'd2;
      3:       len = 23'd64;
      4:       len = 23'd65;
      5:       len = 23'd128;
      6:       len = 23'd129;
      7:       len = 23'd4095;
      8:       len = 23'($urandom_range(0, 4095));
      default: len = 23'($urandom_range(3, 200));
    endcase
    if ($urandom_range(0, 1) == 1) len[22:12] = 11'($urandom());

    r = $urandom_range(0, 5);
    if (r == 0) amp = 23'd0;
    else if (r == 1) amp = 23'd32767;
    else if (r == 2) amp = ttbg_pkg::AMPLITUDE_RST;
    else amp = 23'($urandom_range(0, 32767));
    if ($urandom_range(0, 1) == 1) amp[22:15] = 8'($urandom());

    r = $urandom_range(0, 7);
    if (r == 0) lock = 23'd0;
    else if (r == 1) lock = 23'd1;
    else if (r == 2) lock = ttbg_pkg::LOCKOUT_MS_RST;
    else if (r == 3) lock = 23'd65535;
    else if (r == 4) lock = 23'($urandom_range(0, 65535));
    else lock = 23'($urandom_range(0, 300));
    if ($urandom_range(0, 1) == 1) lock[22:16] = 7'($urandom());

    // a touch-heavy mix now and then keeps the queue full
    tick_pct = ($urandom_range(0, 3) == 0) ? 25 : 80;
    n_items  = $urandom_range(10, 80);

    settle();
    program_regs(step, len, amp, lock);

    repeat (n_items) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        send_item(CMD_TICK, $urandom());
      end else begin
        r = $urandom_range(0, 19);
        if (r < 11) begin
          ms_now = ms_now + 32'(board.lockout_ms) + $urandom_range(0, 40);
          now    = ms_now;
        end else if (r < 14) begin
          // lands inside the window or right on its edge
          ms_now = ms_now + $urandom_range(0, board.lockout_ms);
          now    = ms_now;
        end else if (r < 16) begin
          now = ms_now - $urandom_range(0, 500);
        end else if (r < 18) begin
          now    = $urandom();
          ms_now = now;
        end else if (r == 18) begin
          now = '0;
        end else begin
          now = 32'hFFFF_FFFF;
        end
        send_item(CMD_TOUCH, now);
      end
    end
  endtask

  // result side: check every accepted item, stall in changing patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} rx_pattern_t;
  rx_pattern_t rx_pattern = RX_OPEN;
  int unsigned rx_left    = 0;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      board.check_result(m_tdata, m_tlast, m_tuser);
    end
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left    = $urandom_range(8, 160);
    end else begin
      rx_left--;
    end
    case (rx_pattern)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= (rx_left % 16 == 0);   // long stalls
    endcase
  end

  initial begin
    int start_items;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: lockout history, queue limit, attack ramp
    send_item(CMD_TICK, 32'hFFFF_FFFF);   // nothing queued, all zero
    send_item(CMD_TOUCH, 32'd0);          // time zero leaves history empty
    send_item(CMD_TOUCH, 32'd50);         // no history yet, accepted
    send_item(CMD_TOUCH, 32'd100);        // 50 ms after, locked out
    send_item(CMD_TOUCH, 32'd170);        // exactly the lockout apart
    send_item(CMD_TOUCH, 32'd20);         // earlier stamp is taken
    repeat (4) send_item(CMD_TOUCH, 32'hFFFF_FFFF);  // equal stamps; queue fills
    send_item(CMD_TOUCH, 32'hFFFF_FFFF);  // queue full, nothing queued
    repeat (3) send_item(CMD_TICK, $urandom());

    // burst shortened below the current index ends on the next tick
    settle();
    program_regs(ttbg_pkg::PHASE_STEP_RST, 23'd2, ttbg_pkg::AMPLITUDE_RST,
                 ttbg_pkg::LOCKOUT_MS_RST);
    send_item(CMD_TICK, $urandom());

    // zero length gives one-sample bursts; top step and amplitude
    settle();
    program_regs(23'h7FFFFF, 23'd0, 23'd32767, 23'd0);
    send_item(CMD_TICK, 32'd0);
    send_item(CMD_TICK, $urandom());
    send_item(CMD_TOUCH, 32'd5);

    // high bits above each register dropped; over-long burst, silent amplitude
    settle();
    program_regs(23'd1, 23'h7FFFFF, 23'h7F8000, 23'h7FFFFF);
    send_item(CMD_TICK, $urandom());
    send_item(CMD_TOUCH, 32'd1000);       // inside a 65535 ms window

    // start one burst of the clipped maximum length and play its attack
    settle();
    program_regs(23'($urandom()), 23'(LONGEST_BURST + $urandom_range(0, 255)),
                 23'd32767, 23'd0);
    send_item(CMD_TOUCH, $urandom());
    repeat (40) send_item(CMD_TICK, $urandom());

    start_items = fed_items;
    while (fed_items - start_items < RANDOM_ITEMS) random_phase();

    settle();
    if (board.errors == 0 && board.due.size() == 0) begin
      $display("tb_touch_tone_burst_generator: clean");
    end else begin
      $display("tb_touch_tone_burst_generator: errors");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("tb_touch_tone_burst_generator: errors");
    $finish;
  end

endmodule
